// File: rtl/hmflc_pkg.sv
// ----------------------------------------------------------------------------
// hmflc_pkg
// Shared widths, register indexes, mode and reason codes, and the types
// passed between the humidity / motion fan and light controller modules.
// ----------------------------------------------------------------------------
package hmflc_pkg;

  // sample window
  localparam int WINDOW_DEPTH = 10;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  // field widths
  localparam int RH_W     = 10;
  localparam int TIME_W   = 32;
  localparam int HOLD_W   = 16;
  localparam int LEVEL_W  = 7;
  localparam int MODE_W   = 2;
  localparam int LREASON_W = 2;
  localparam int FREASON_W = 3;

  // hold time in ms is seconds times 1000
  localparam int HOLD_SCALE = 1000;
  localparam int LIMIT_W    = HOLD_W + $clog2(HOLD_SCALE);

  // humidity levels in tenths; soft bound is 9*off + on
  localparam int TENTH_SCALE = 10;
  localparam int SOFT_OFF_MUL = TENTH_SCALE - 1;
  localparam int TENTHS_W     = LEVEL_W + 4;

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_LIGHT_HOLD = 3'd0;
  localparam logic [IDX_W-1:0] REG_FAN_HOLD   = 3'd1;
  localparam logic [IDX_W-1:0] REG_ON_LEVEL   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFF_LEVEL  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LIGHT_MODE = 3'd4;
  localparam logic [IDX_W-1:0] REG_FAN_MODE   = 3'd5;

  // mode selector codes; the unused code behaves as forced off
  localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd2;

  // light reason codes
  localparam logic [LREASON_W-1:0] LR_NONE   = 2'd0;
  localparam logic [LREASON_W-1:0] LR_MOTION = 2'd1;
  localparam logic [LREASON_W-1:0] LR_FORCED = 2'd2;

  // fan reason codes
  localparam logic [FREASON_W-1:0] FR_NONE   = 3'd0;
  localparam logic [FREASON_W-1:0] FR_HIGH   = 3'd1;
  localparam logic [FREASON_W-1:0] FR_LOW    = 3'd2;
  localparam logic [FREASON_W-1:0] FR_SOFT   = 3'd3;
  localparam logic [FREASON_W-1:0] FR_MOTION = 3'd4;
  localparam logic [FREASON_W-1:0] FR_FORCED = 3'd5;

  // decoded configuration handed to the datapath
  typedef struct packed {
    logic [LIMIT_W-1:0]  light_limit;
    logic [LIMIT_W-1:0]  fan_limit;
    logic [TENTHS_W-1:0] on_tenths;
    logic [TENTHS_W-1:0] off_tenths;
    logic [TENTHS_W-1:0] soft_bound;
    logic [MODE_W-1:0]   light_sel;
    logic [MODE_W-1:0]   fan_sel;
    logic                clear_window;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic                 light_on;
    logic                 fan_on;
    logic [LREASON_W-1:0] light_reason;
    logic [FREASON_W-1:0] fan_reason;
  } res_t;

endpackage

// File: rtl/hmflc_in_if.sv
// ----------------------------------------------------------------------------
// hmflc_in_if
// Sample channel: valid / ready handshake with humidity, motion and time.
// ----------------------------------------------------------------------------
interface hmflc_in_if;
  logic                           valid;
  logic                           ready;
  logic [hmflc_pkg::RH_W-1:0]     humidity_tenths;
  logic                           motion_seen;
  logic [hmflc_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, output humidity_tenths, output motion_seen,
                  output now_ms, input ready);
  modport sink (input valid, input humidity_tenths, input motion_seen,
                input now_ms, output ready);
endinterface

// File: rtl/hmflc_out_if.sv
// ----------------------------------------------------------------------------
// hmflc_out_if
// Command channel: valid / ready handshake with light and fan commands.
// ----------------------------------------------------------------------------
interface hmflc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              light_on;
  logic                              fan_on;
  logic [hmflc_pkg::LREASON_W-1:0]   light_reason;
  logic [hmflc_pkg::FREASON_W-1:0]   fan_reason;

  modport source (output valid, output light_on, output fan_on,
                  output light_reason, output fan_reason, input ready);
  modport sink (input valid, input light_on, input fan_on,
                input light_reason, input fan_reason, output ready);
endinterface

// File: rtl/hmflc_cfg.sv
// ----------------------------------------------------------------------------
// hmflc_cfg
// APB-style register file; keeps the hold limits in ms precomputed and
// flags a window flush on every write to a listed register.
// ----------------------------------------------------------------------------
module hmflc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hmflc_pkg::ADDR_W-1:0]  paddr,
  input  logic [hmflc_pkg::DATA_W-1:0]  pwdata,
  output logic [hmflc_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output hmflc_pkg::cfg_t               cfg
);

  logic [hmflc_pkg::HOLD_W-1:0]   light_hold_r, light_hold_nxt;
  logic [hmflc_pkg::HOLD_W-1:0]   fan_hold_r, fan_hold_nxt;
  logic [hmflc_pkg::LIMIT_W-1:0]  light_limit_r, light_limit_nxt;
  logic [hmflc_pkg::LIMIT_W-1:0]  fan_limit_r, fan_limit_nxt;
  logic [hmflc_pkg::LEVEL_W-1:0]  on_level_r, on_level_nxt;
  logic [hmflc_pkg::LEVEL_W-1:0]  off_level_r, off_level_nxt;
  logic [hmflc_pkg::MODE_W-1:0]   light_sel_r, light_sel_nxt;
  logic [hmflc_pkg::MODE_W-1:0]   fan_sel_r, fan_sel_nxt;
  logic                           wr_en;
  logic                           clear;
  logic [hmflc_pkg::IDX_W-1:0]    idx;
  logic [hmflc_pkg::LIMIT_W-1:0]  wr_limit;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[hmflc_pkg::ADDR_W-1:2];

  // hold seconds scaled to ms once, at write time
  assign wr_limit = hmflc_pkg::LIMIT_W'(
    32'(pwdata[hmflc_pkg::HOLD_W-1:0]) * 32'(hmflc_pkg::HOLD_SCALE));

  // register write decode
  always_comb begin
    light_hold_nxt  = light_hold_r;
    fan_hold_nxt    = fan_hold_r;
    light_limit_nxt = light_limit_r;
    fan_limit_nxt   = fan_limit_r;
    on_level_nxt    = on_level_r;
    off_level_nxt   = off_level_r;
    light_sel_nxt   = light_sel_r;
    fan_sel_nxt     = fan_sel_r;
    clear           = 1'b0;
    if (wr_en) begin
      unique case (idx)
        hmflc_pkg::REG_LIGHT_HOLD: begin
          light_hold_nxt  = pwdata[hmflc_pkg::HOLD_W-1:0];
          light_limit_nxt = wr_limit;
          clear           = 1'b1;
        end
        hmflc_pkg::REG_FAN_HOLD: begin
          fan_hold_nxt  = pwdata[hmflc_pkg::HOLD_W-1:0];
          fan_limit_nxt = wr_limit;
          clear         = 1'b1;
        end
        hmflc_pkg::REG_ON_LEVEL: begin
          on_level_nxt = pwdata[hmflc_pkg::LEVEL_W-1:0];
          clear        = 1'b1;
        end
        hmflc_pkg::REG_OFF_LEVEL: begin
          off_level_nxt = pwdata[hmflc_pkg::LEVEL_W-1:0];
          clear         = 1'b1;
        end
        hmflc_pkg::REG_LIGHT_MODE: begin
          light_sel_nxt = pwdata[hmflc_pkg::MODE_W-1:0];
          clear         = 1'b1;
        end
        hmflc_pkg::REG_FAN_MODE: begin
          fan_sel_nxt = pwdata[hmflc_pkg::MODE_W-1:0];
          clear       = 1'b1;
        end
        default: begin
          clear = 1'b0;
        end
      endcase
    end
  end

  // register state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_hold_r  <= '0;
      fan_hold_r    <= '0;
      light_limit_r <= '0;
      fan_limit_r   <= '0;
      on_level_r    <= '0;
      off_level_r   <= '0;
      light_sel_r   <= hmflc_pkg::MODE_AUTO;
      fan_sel_r     <= hmflc_pkg::MODE_AUTO;
    end else begin
      light_hold_r  <= light_hold_nxt;
      fan_hold_r    <= fan_hold_nxt;
      light_limit_r <= light_limit_nxt;
      fan_limit_r   <= fan_limit_nxt;
      on_level_r    <= on_level_nxt;
      off_level_r   <= off_level_nxt;
      light_sel_r   <= light_sel_nxt;
      fan_sel_r     <= fan_sel_nxt;
    end
  end

  // readback
  always_comb begin
    unique case (idx)
      hmflc_pkg::REG_LIGHT_HOLD: prdata = hmflc_pkg::DATA_W'(light_hold_r);
      hmflc_pkg::REG_FAN_HOLD:   prdata = hmflc_pkg::DATA_W'(fan_hold_r);
      hmflc_pkg::REG_ON_LEVEL:   prdata = hmflc_pkg::DATA_W'(on_level_r);
      hmflc_pkg::REG_OFF_LEVEL:  prdata = hmflc_pkg::DATA_W'(off_level_r);
      hmflc_pkg::REG_LIGHT_MODE: prdata = hmflc_pkg::DATA_W'(light_sel_r);
      hmflc_pkg::REG_FAN_MODE:   prdata = hmflc_pkg::DATA_W'(fan_sel_r);
      default:                   prdata = '0;
    endcase
  end

  // levels in tenths and the soft-down bound 9*off + on
  always_comb begin
    cfg.light_limit  = light_limit_r;
    cfg.fan_limit    = fan_limit_r;
    cfg.on_tenths    = hmflc_pkg::TENTHS_W'(on_level_r) *
                       hmflc_pkg::TENTHS_W'(hmflc_pkg::TENTH_SCALE);
    cfg.off_tenths   = hmflc_pkg::TENTHS_W'(off_level_r) *
                       hmflc_pkg::TENTHS_W'(hmflc_pkg::TENTH_SCALE);
    cfg.soft_bound   = hmflc_pkg::TENTHS_W'(off_level_r) *
                       hmflc_pkg::TENTHS_W'(hmflc_pkg::SOFT_OFF_MUL) +
                       hmflc_pkg::TENTHS_W'(on_level_r);
    cfg.light_sel    = light_sel_r;
    cfg.fan_sel      = fan_sel_r;
    cfg.clear_window = clear;
  end

endmodule

// File: rtl/hmflc_cell.sv
// ----------------------------------------------------------------------------
// hmflc_cell
// One window cell: holds one older sample, passes it right on each beat and
// adds its own bound check to the running all-below flag.
// ----------------------------------------------------------------------------
module hmflc_cell (
  input  logic                            clk,
  input  logic                            shift_en,
  input  logic [hmflc_pkg::RH_W-1:0]      d_in,
  input  logic [hmflc_pkg::TENTHS_W-1:0]  bound,
  input  logic                            ok_in,
  output logic [hmflc_pkg::RH_W-1:0]      q,
  output logic                            ok_out
);

  logic [hmflc_pkg::RH_W-1:0] sample_r;

  // sample storage, shifts with every accepted beat
  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample_r <= d_in;
    end
  end

  assign q      = sample_r;
  assign ok_out = ok_in & (hmflc_pkg::TENTHS_W'(sample_r) <= bound);

endmodule

// File: rtl/hmflc_window.sv
// ----------------------------------------------------------------------------
// hmflc_window
// Recent-sample window as a row of cells plus a fill count. Reports whether
// the window including the incoming sample is full and entirely at or below
// the soft bound.
// ----------------------------------------------------------------------------
module hmflc_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            shift_en,
  input  logic                            clear,
  input  logic [hmflc_pkg::RH_W-1:0]      sample_in,
  input  logic [hmflc_pkg::TENTHS_W-1:0]  bound,
  output logic                            soft_ready
);

  localparam int NCELL = hmflc_pkg::WINDOW_DEPTH - 1;

  logic [hmflc_pkg::RH_W-1:0]  q [NCELL];
  logic                        ok [NCELL+1];
  logic [hmflc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        full_next;

  // incoming sample starts the check chain
  assign ok[0] = hmflc_pkg::TENTHS_W'(sample_in) <= bound;

  // the incoming sample plus the cells form the window after this beat
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    hmflc_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     ((i == 0) ? sample_in : q[(i == 0) ? 0 : i-1]),
      .bound    (bound),
      .ok_in    (ok[i]),
      .q        (q[i]),
      .ok_out   (ok[i+1])
    );
  end

  // fill count saturates at the window depth
  assign full_next = cnt_r >= hmflc_pkg::CNT_W'(hmflc_pkg::WINDOW_DEPTH - 1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (clear) begin
      cnt_nxt = '0;
    end else if (shift_en && !full_next) begin
      cnt_nxt = cnt_r + hmflc_pkg::CNT_W'(1);
    end else if (shift_en) begin
      cnt_nxt = hmflc_pkg::CNT_W'(hmflc_pkg::WINDOW_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign soft_ready = full_next & ok[NCELL];

`ifndef SYNTHESIS
  // fill count never passes the depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= hmflc_pkg::CNT_W'(hmflc_pkg::WINDOW_DEPTH))
    else $error("window count above depth");

  // a flush empties the window on the next cycle
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> cnt_r == '0)
    else $error("window not emptied after config write");
`endif

endmodule

// File: rtl/humidity_motion_fan_light_controller.sv
// ----------------------------------------------------------------------------
// humidity_motion_fan_light_controller
// Light and fan commands from humidity samples, motion and a ms timestamp,
// with hold timers, a humidity latch with soft release and forced modes.
// ----------------------------------------------------------------------------
//  port     | direction | carries
//  ---------+-----------+----------------------------------------------
//  in_ch    | sink      | humidity_tenths, motion_seen, now_ms
//  out_ch   | source    | light_on, fan_on, light_reason, fan_reason
//  cfg_*    | slave     | APB register port, registers at 4 * index
//
// One sample beat per cycle while the skid is empty; its result is registered in the output register, or in the skid
// while the output waits. All decisions for a beat are made in the cycle of acceptance: the hold compares, the
// latch compares and the AND chain through the window cells.
// An output register plus a one-entry skid keep input accepting while a
// result waits; input stalls only while the skid is occupied.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module humidity_motion_fan_light_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  hmflc_in_if.sink                      in_ch,
  hmflc_out_if.source                   out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [hmflc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [hmflc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [hmflc_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  hmflc_pkg::cfg_t                 cfg;
  logic                            acc;
  logic                            soft_ready;
  logic [hmflc_pkg::TIME_W-1:0]    last_motion_r, last_motion_nxt;
  logic                            latch_r, latch_nxt;
  logic [hmflc_pkg::FREASON_W-1:0] fan_reason_r, fan_reason_nxt;
  logic [hmflc_pkg::TIME_W-1:0]    elapsed;
  logic                            light_m, fan_m;
  hmflc_pkg::res_t                 res;
  hmflc_pkg::res_t                 out_r, out_nxt;
  hmflc_pkg::res_t                 skid_r, skid_nxt;
  logic                            out_v_r, out_v_nxt;
  logic                            skid_v_r, skid_v_nxt;

  // register port
  hmflc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = !skid_v_r;
  assign acc         = in_ch.valid & in_ch.ready;

  // sample window
  hmflc_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (acc),
    .clear      (cfg.clear_window),
    .sample_in  (in_ch.humidity_tenths),
    .bound      (cfg.soft_bound),
    .soft_ready (soft_ready)
  );

  // hold timers on wrapped elapsed time
  assign elapsed = in_ch.now_ms - last_motion_r;
  assign light_m = in_ch.motion_seen |
                   (elapsed < hmflc_pkg::TIME_W'(cfg.light_limit));
  assign fan_m   = in_ch.motion_seen |
                   (elapsed < hmflc_pkg::TIME_W'(cfg.fan_limit));

  // per-beat decision
  always_comb begin
    latch_nxt       = latch_r;
    fan_reason_nxt  = fan_reason_r;
    last_motion_nxt = last_motion_r;
    res             = '0;

    if (in_ch.motion_seen) begin
      last_motion_nxt = in_ch.now_ms;
    end

    // humidity latch, high check first
    if (hmflc_pkg::TENTHS_W'(in_ch.humidity_tenths) >= cfg.on_tenths) begin
      latch_nxt      = 1'b1;
      fan_reason_nxt = hmflc_pkg::FR_HIGH;
    end else if (hmflc_pkg::TENTHS_W'(in_ch.humidity_tenths) <= cfg.off_tenths) begin
      latch_nxt      = 1'b0;
      fan_reason_nxt = hmflc_pkg::FR_LOW;
    end else if (latch_r && soft_ready) begin
      latch_nxt      = 1'b0;
      fan_reason_nxt = hmflc_pkg::FR_SOFT;
    end

    // motion hold wins over the latch
    if (fan_m) begin
      res.fan_on     = 1'b1;
      fan_reason_nxt = hmflc_pkg::FR_MOTION;
    end else begin
      res.fan_on = latch_nxt;
    end

    res.light_on     = light_m;
    res.light_reason = hmflc_pkg::LR_MOTION;

    // forced modes
    if (cfg.light_sel != hmflc_pkg::MODE_AUTO) begin
      res.light_on     = (cfg.light_sel == hmflc_pkg::MODE_ON);
      res.light_reason = hmflc_pkg::LR_FORCED;
    end
    if (cfg.fan_sel != hmflc_pkg::MODE_AUTO) begin
      res.fan_on     = (cfg.fan_sel == hmflc_pkg::MODE_ON);
      fan_reason_nxt = hmflc_pkg::FR_FORCED;
    end

    res.fan_reason = fan_reason_nxt;
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_motion_r <= '0;
      latch_r       <= 1'b0;
      fan_reason_r  <= hmflc_pkg::FR_NONE;
    end else if (acc) begin
      last_motion_r <= last_motion_nxt;
      latch_r       <= latch_nxt;
      fan_reason_r  <= fan_reason_nxt;
    end
  end

  // output register with one-entry skid
  always_comb begin
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = res;
        out_v_nxt = acc;
      end
    end else if (acc) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.light_on     = out_r.light_on;
  assign out_ch.fan_on       = out_r.fan_on;
  assign out_ch.light_reason = out_r.light_reason;
  assign out_ch.fan_reason   = out_r.fan_reason;

`ifndef SYNTHESIS
  // skid holds a beat only behind a waiting output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid beat without output beat");

  // every accepted sample leaves a result waiting next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_v_r)
    else $error("accepted beat produced no result");
`endif

endmodule
